// ===== rtl/bpc_pkg.sv =====
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types and constants for the barometric pressure compensation block.
// ----------------------------------------------------------------------------
package bpc_pkg;

    typedef enum logic [1:0] {
        CFG_TEMP    = 2'd0,
        CFG_PRESS_A = 2'd1,
        CFG_PRESS_B = 2'd2,
        CFG_PRESS_C = 2'd3
    } t_cfg_idx;

    // sideband that rides along the divider
    typedef struct packed {
        logic signed [15:0] temp;
        logic               zero;
    } t_side;

endpackage

// ===== rtl/bpc_if.sv =====
// ----------------------------------------------------------------------------
// bpc_if
// Request, result and configuration channels of the pressure compensation block.
// ----------------------------------------------------------------------------
interface bpc_in_if;
    logic        valid;
    logic        ready;
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;

    modport source (output valid, raw_temperature, raw_pressure, input ready);
    modport sink   (input valid, raw_temperature, raw_pressure, output ready);
endinterface

interface bpc_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] comp_temp;
    logic        [31:0] comp_press;
    logic               valid_res;

    modport source (output valid, comp_temp, comp_press, valid_res,
                    input ready);
    modport sink   (input valid, comp_temp, comp_press, valid_res,
                    output ready);
endinterface

interface bpc_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [63:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/barometric_pressure_compensation.sv =====
// ----------------------------------------------------------------------------
// barometric_pressure_compensation
// Integer temperature and pressure compensation of a barometric sensor.
// ----------------------------------------------------------------------------
// Takes one raw temperature/pressure pair per clock while the pipeline is not
// stopped and raises o_out.valid for its result from the output register;
// results leave in order. The divider makes up most of the pipeline; the
// pipeline stops as a whole only when both the output register and its skid
// entry are full. Calibration words are written through the cfg channel,
// which is always ready; write them only while no request is in flight. A
// zero divisor gives valid_res low with both values zero.
module barometric_pressure_compensation
    import bpc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    bpc_in_if.sink     i_in,
    bpc_out_if.source  o_out,
    bpc_cfg_if.sink    i_cfg
);

    localparam int unsigned NSTG = 81;

    // calibration
    logic [47:0] r_cal_t;
    logic [63:0] r_cal_a;
    logic [63:0] r_cal_b;
    logic [15:0] r_cal_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_t <= '0;
            r_cal_a <= '0;
            r_cal_b <= '0;
            r_cal_c <= '0;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_TEMP:    r_cal_t <= i_cfg.data[47:0];
                CFG_PRESS_A: r_cal_a <= i_cfg.data;
                CFG_PRESS_B: r_cal_b <= i_cfg.data;
                CFG_PRESS_C: r_cal_c <= i_cfg.data[15:0];
                default: ;
            endcase
        end
    end

    assign i_cfg.ready = 1'b1;

    logic        [15:0] n_t1;
    logic signed [15:0] n_t2, n_t3;
    logic        [15:0] n_p1;
    logic signed [15:0] n_p2, n_p3, n_p4, n_p5, n_p6, n_p7, n_p8, n_p9;

    assign n_t1 = r_cal_t[15:0];
    assign n_t2 = r_cal_t[31:16];
    assign n_t3 = r_cal_t[47:32];
    assign n_p1 = r_cal_a[15:0];
    assign n_p2 = r_cal_a[31:16];
    assign n_p3 = r_cal_a[47:32];
    assign n_p4 = r_cal_a[63:48];
    assign n_p5 = r_cal_b[15:0];
    assign n_p6 = r_cal_b[31:16];
    assign n_p7 = r_cal_b[47:32];
    assign n_p8 = r_cal_b[63:48];
    assign n_p9 = r_cal_c;

    // flow control
    logic            r_ov, r_sv;
    logic [NSTG-1:0] r_v;
    logic            n_en, n_fire, n_push, n_pop;

    assign n_en        = !r_sv;
    assign i_in.ready  = n_en;
    assign n_fire      = i_in.valid && n_en;
    assign n_push      = r_v[NSTG-1] && n_en;
    assign n_pop       = r_ov && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (n_en) begin
            r_v <= {r_v[NSTG-2:0], n_fire};
        end
    end

    // stage 1
    logic signed [17:0] n1_x;
    logic signed [16:0] n1_dt;
    logic        [20:0] n1_p0;
    logic signed [17:0] r1_x;
    logic signed [16:0] r1_dt;
    logic        [20:0] r1_p0;

    assign n1_x  = $signed({1'b0, i_in.raw_temperature[19:3]})
                 - $signed({1'b0, n_t1, 1'b0});
    assign n1_dt = $signed({1'b0, i_in.raw_temperature[19:4]}) - $signed({1'b0, n_t1});
    assign n1_p0 = 21'h100000 - {1'b0, i_in.raw_pressure};

    // stage 2
    logic signed [33:0] n2_m1, n2_m2;
    logic        [31:0] r2_m1, r2_m2;
    logic        [20:0] r2_p0;

    assign n2_m1 = r1_x * n_t2;
    assign n2_m2 = r1_dt * r1_dt;

    // stage 3
    logic signed [35:0] n3_m3;
    logic        [20:0] r3_v1;
    logic        [31:0] r3_m3;
    logic        [20:0] r3_p0;

    assign n3_m3 = $signed(r2_m2[31:12]) * n_t3;

    // stage 4
    logic [31:0] r4_fine;
    logic [20:0] r4_p0;

    // stage 5
    logic        [31:0] n5_t;
    logic signed [33:0] r5_a;
    logic        [15:0] r5_t;
    logic        [20:0] r5_p0;

    assign n5_t = {r4_fine[29:0], 2'b00} + r4_fine + 32'd128;

    // stage 6
    logic signed [67:0] n6_aa;
    logic signed [49:0] n6_ap5, n6_ap2;
    logic        [63:0] r6_aa;
    logic signed [49:0] r6_ap5, r6_ap2;
    logic        [15:0] r6_t;
    logic        [20:0] r6_p0;

    assign n6_aa  = r5_a * r5_a;
    assign n6_ap5 = r5_a * n_p5;
    assign n6_ap2 = r5_a * n_p2;

    // stage 7
    logic signed [79:0] n7_aa6, n7_aa3;
    logic        [63:0] r7_aa6, r7_aa3;
    logic signed [49:0] r7_ap5, r7_ap2;
    logic        [15:0] r7_t;
    logic        [20:0] r7_p0;

    assign n7_aa6 = $signed(r6_aa) * n_p6;
    assign n7_aa3 = $signed(r6_aa) * n_p3;

    // stage 8
    logic [63:0] n8_ap5, n8_ap2, n8_p4;
    logic [63:0] r8_b, r8_a2;
    logic [15:0] r8_t;
    logic [20:0] r8_p0;

    assign n8_ap5 = {{14{r7_ap5[49]}}, r7_ap5};
    assign n8_ap2 = {{14{r7_ap2[49]}}, r7_ap2};
    assign n8_p4  = {{48{n_p4[15]}}, n_p4};

    // stage 9
    logic [63:0] n9_ad;
    logic [79:0] n9_pr;
    logic [63:0] r9_pr, r9_nb;
    logic [15:0] r9_t;

    assign n9_ad = 64'h0000_8000_0000_0000 + r8_a2;
    assign n9_pr = n9_ad * n_p1;

    // stage 10
    logic [75:0] n10_n;
    logic [63:0] r10_d, r10_n;
    t_side       r10_side;

    assign n10_n = r9_nb * 12'd3125;

    // divider, stages 11 to 76
    logic [63:0] n_quo;
    t_side       n_qside;

    bpc_div u_div (
        .i_clk  (i_clk),
        .i_en   (n_en),
        .i_num  (r10_n),
        .i_den  (r10_d),
        .i_side (r10_side),
        .o_quo  (n_quo),
        .o_side (n_qside)
    );

    // stage 77
    logic [63:0] n77_s;
    logic [63:0] n77_ll, n77_lh;
    logic signed [79:0] n77_p8q;
    logic [63:0] r77_ll, r77_p8q, r77_q;
    logic [30:0] r77_lh;
    t_side       r77_side;

    assign n77_s   = {{13{n_quo[63]}}, n_quo[63:13]};
    assign n77_ll  = n77_s[31:0] * n77_s[31:0];
    assign n77_lh  = n77_s[31:0] * n77_s[63:32];
    assign n77_p8q = $signed(n_quo) * n_p8;

    // stage 78
    logic [63:0] r78_ss, r78_p8q, r78_q;
    t_side       r78_side;

    // stage 79
    logic signed [79:0] n79_ap9;
    logic [63:0] r79_ap9, r79_bq, r79_q;
    t_side       r79_side;

    assign n79_ap9 = $signed(r78_ss) * n_p9;

    // stage 80
    logic [63:0] r80_sum;
    t_side       r80_side;

    // stage 81
    logic [63:0] n81_p;
    logic signed [15:0] r81_t;
    logic [31:0] r81_pa;
    logic        r81_ok;

    assign n81_p = {{8{r80_sum[63]}}, r80_sum[63:8]} + ({{48{n_p7[15]}}, n_p7} << 4);

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r1_x  <= n1_x;
            r1_dt <= n1_dt;
            r1_p0 <= n1_p0;

            r2_m1 <= n2_m1[31:0];
            r2_m2 <= n2_m2[31:0];
            r2_p0 <= r1_p0;

            r3_v1 <= r2_m1[31:11];
            r3_m3 <= n3_m3[31:0];
            r3_p0 <= r2_p0;

            r4_fine <= {{11{r3_v1[20]}}, r3_v1} + {{14{r3_m3[31]}}, r3_m3[31:14]};
            r4_p0   <= r3_p0;

            r5_t  <= n5_t[23:8];
            r5_a  <= $signed({{2{r4_fine[31]}}, r4_fine}) - 34'sd128000;
            r5_p0 <= r4_p0;

            r6_aa  <= n6_aa[63:0];
            r6_ap5 <= n6_ap5;
            r6_ap2 <= n6_ap2;
            r6_t   <= r5_t;
            r6_p0  <= r5_p0;

            r7_aa6 <= n7_aa6[63:0];
            r7_aa3 <= n7_aa3[63:0];
            r7_ap5 <= r6_ap5;
            r7_ap2 <= r6_ap2;
            r7_t   <= r6_t;
            r7_p0  <= r6_p0;

            r8_b  <= r7_aa6 + (n8_ap5 << 17) + (n8_p4 << 35);
            r8_a2 <= {{8{r7_aa3[63]}}, r7_aa3[63:8]} + (n8_ap2 << 12);
            r8_t  <= r7_t;
            r8_p0 <= r7_p0;

            r9_pr <= n9_pr[63:0];
            r9_nb <= {12'd0, r8_p0, 31'd0} - r8_b;
            r9_t  <= r8_t;

            r10_d         <= {{33{r9_pr[63]}}, r9_pr[63:33]};
            r10_n         <= n10_n[63:0];
            r10_side.temp <= r9_t;
            r10_side.zero <= (r9_pr[63:33] == 31'd0);

            r77_ll   <= n77_ll;
            r77_lh   <= n77_lh[30:0];
            r77_p8q  <= n77_p8q[63:0];
            r77_q    <= n_quo;
            r77_side <= n_qside;

            r78_ss   <= r77_ll + {r77_lh, 33'd0};
            r78_p8q  <= r77_p8q;
            r78_q    <= r77_q;
            r78_side <= r77_side;

            r79_ap9  <= n79_ap9[63:0];
            r79_bq   <= {{19{r78_p8q[63]}}, r78_p8q[63:19]};
            r79_q    <= r78_q;
            r79_side <= r78_side;

            r80_sum  <= r79_q + {{25{r79_ap9[63]}}, r79_ap9[63:25]} + r79_bq;
            r80_side <= r79_side;

            r81_t  <= r80_side.zero ? 16'sd0 : r80_side.temp;
            r81_pa <= r80_side.zero ? 32'd0 : n81_p[39:8];
            r81_ok <= !r80_side.zero;
        end
    end

    // output register with skid entry
    logic signed [15:0] r_ot, r_st;
    logic        [31:0] r_op, r_sp;
    logic               r_ok, r_sk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (r_sv) begin
            if (n_pop) begin
                r_sv <= 1'b0;
            end
        end else if (!r_ov || n_pop) begin
            r_ov <= n_push;
        end else if (n_push) begin
            r_sv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sv) begin
            if (n_pop) begin
                r_ot <= r_st;
                r_op <= r_sp;
                r_ok <= r_sk;
            end
        end else if (!r_ov || n_pop) begin
            r_ot <= r81_t;
            r_op <= r81_pa;
            r_ok <= r81_ok;
        end else begin
            r_st <= r81_t;
            r_sp <= r81_pa;
            r_sk <= r81_ok;
        end
    end

    assign o_out.valid      = r_ov;
    assign o_out.comp_temp  = r_ot;
    assign o_out.comp_press = r_op;
    assign o_out.valid_res  = r_ok;

endmodule

// ===== rtl/bpc_div.sv =====
// ----------------------------------------------------------------------------
// bpc_div
// Pipelined signed 64-bit divider, truncating toward zero. One stage for the
// magnitudes, 64 restoring stages (one quotient bit each), one sign stage.
// ----------------------------------------------------------------------------
module bpc_div
    import bpc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_num,
    input  logic [63:0] i_den,
    input  t_side       i_side,
    output logic [63:0] o_quo,
    output t_side       o_side
);

    logic [63:0] r_an;
    logic [63:0] r_ad;
    logic        r_neg0;
    t_side       r_side0;

    logic [63:0] r_rem  [0:63];
    logic [63:0] r_quo  [0:63];
    logic [63:0] r_den  [0:63];
    logic        r_neg  [0:63];
    t_side       r_side [0:63];

    logic [63:0] r_q;
    t_side       r_sideq;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_an    <= i_num[63] ? (64'd0 - i_num) : i_num;
            r_ad    <= i_den[63] ? (64'd0 - i_den) : i_den;
            r_neg0  <= i_num[63] ^ i_den[63];
            r_side0 <= i_side;
        end
    end

    for (genvar j = 0; j < 64; j++) begin : g_stg
        logic [63:0] n_rem_in;
        logic [63:0] n_quo_in;
        logic [63:0] n_den_in;
        logic        n_neg_in;
        t_side       n_side_in;
        logic [64:0] n_tr;
        logic [64:0] n_df;

        if (j == 0) begin : g_first
            assign n_rem_in  = 64'd0;
            assign n_quo_in  = r_an;
            assign n_den_in  = r_ad;
            assign n_neg_in  = r_neg0;
            assign n_side_in = r_side0;
        end else begin : g_next
            assign n_rem_in  = r_rem[j-1];
            assign n_quo_in  = r_quo[j-1];
            assign n_den_in  = r_den[j-1];
            assign n_neg_in  = r_neg[j-1];
            assign n_side_in = r_side[j-1];
        end

        assign n_tr = {n_rem_in, n_quo_in[63]};
        assign n_df = n_tr - {1'b0, n_den_in};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!n_df[64]) begin
                    r_rem[j] <= n_df[63:0];
                    r_quo[j] <= {n_quo_in[62:0], 1'b1};
                end else begin
                    r_rem[j] <= n_tr[63:0];
                    r_quo[j] <= {n_quo_in[62:0], 1'b0};
                end
                r_den[j]  <= n_den_in;
                r_neg[j]  <= n_neg_in;
                r_side[j] <= n_side_in;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q     <= r_neg[63] ? (64'd0 - r_quo[63]) : r_quo[63];
            r_sideq <= r_side[63];
        end
    end

    assign o_quo  = r_q;
    assign o_side = r_sideq;

endmodule

// ===== rtl/bpc_chk.sv =====
// ----------------------------------------------------------------------------
// bpc_chk
// Port-level checks for barometric_pressure_compensation, bound to the top.
// ----------------------------------------------------------------------------
module bpc_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_out_temp,
    input logic [31:0] i_out_press,
    input logic        i_out_ok,
    input logic        i_cfg_ready
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_temp)
            && $stable(i_out_press) && $stable(i_out_ok))
        else $error("result changed while stalled");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ok |-> i_out_temp == 16'd0 && i_out_press == 32'd0)
        else $error("invalid result carries nonzero values");

    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input stalled with no result pending");

    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && i_in_ready)
        else $error("result or stall shown after reset");

    a_cfg_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_ready)
        else $error("configuration channel stalled");

endmodule

bind barometric_pressure_compensation bpc_chk u_bpc_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_temp  (o_out.comp_temp),
    .i_out_press (o_out.comp_press),
    .i_out_ok    (o_out.valid_res),
    .i_cfg_ready (i_cfg.ready)
);
